### src/sorted_key_binary_search_assert.svh
// Assertion macros used by the sorted key binary search checker.
`ifndef SORTED_KEY_BINARY_SEARCH_ASSERT_SVH
`define SORTED_KEY_BINARY_SEARCH_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SKB_ASSERT_IMPLY(lbl, clk, rst_n, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ant) |-> (cons)) \
		else $error("skb assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SKB_ASSERT_NEXT(lbl, clk, rst_n, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ant) |=> (cons)) \
		else $error("skb assertion failed");

`endif

### src/skb_pkg.sv
// Types and constants of the sorted key binary search block.
package skb_pkg;

	localparam int KEY_W     = 32;
	localparam int IDX_W     = 10;
	localparam int POS_W     = 10;
	localparam int CNT_W     = 11;
	localparam int DEPTH_DEF = 1024;

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	typedef struct packed {
		logic             command;
		logic [IDX_W-1:0] load_index;
		logic [KEY_W-1:0] load_key;
		logic [KEY_W-1:0] search_key;
	} skb_req_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
	} skb_rsp_t;

	typedef struct packed {
		logic busy;
		logic done;
	} skb_status_t;

endpackage

### src/sorted_key_binary_search.sv
// Top level of the sorted key binary search block.
//
// Request channel req (valid/ready) carries either a load item, which writes
// load_key at load_index, or a search item for search_key. Loads give no
// response; an index at or beyond TABLE_DEPTH is dropped. Each search gives
// one response item on rsp (valid/ready): found and the matching position,
// position 0 when not found. cfg_we/cfg_data write entry_count, the number of
// entries searched (saturated to TABLE_DEPTH); write it only while idle.
// A search probes one midpoint per cycle through the key store's registered
// read port; the number of probes is at most clog2(entry_count + 1), so 11
// for a full 1024-entry store. An empty window answers without a probe.
// req_ready is low while a search runs and while a response is held by a
// stalled receiver; the response register holds it unchanged.
// Reset clears entry_count and all control state; the key store is not
// cleared and must be loaded before it is searched.
module sorted_key_binary_search import skb_pkg::*; #(
	parameter int TABLE_DEPTH = DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  skb_req_t         req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output skb_rsp_t         rsp,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_data
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int LW = (CNT_W > CW) ? CNT_W : CW;
	localparam int IW = (IDX_W > CW) ? IDX_W : CW;

	logic [CNT_W-1:0] count_q;
	logic [CW-1:0]    limit;
	logic             req_fire;
	logic             load_we;
	logic             search_start;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic [KEY_W-1:0] rd_data;
	skb_rsp_t         result;
	skb_status_t      status;
	logic             rsp_valid_q;
	skb_rsp_t         rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_we) begin
			count_q <= cfg_data;
		end
	end

	assign limit = (LW'(count_q) > LW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(count_q);

	assign req_ready    = !status.busy && (!rsp_valid_q || rsp_ready);
	assign req_fire     = req_valid && req_ready;
	assign search_start = req_fire && (req.command == CMD_SEARCH);
	assign load_we      = req_fire && (req.command == CMD_LOAD)
	                      && (IW'(req.load_index) < IW'(TABLE_DEPTH));

	skb_key_ram #(
		.DEPTH(TABLE_DEPTH),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (load_we),
		.waddr(AW'(req.load_index)),
		.wdata(req.load_key),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	skb_search_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.AW         (AW),
		.CW         (CW)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (search_start),
		.key    (req.search_key),
		.limit  (limit),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.result (result),
		.status (status)
	);

	// the slot is free whenever a search completes, since req_ready required it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (status.done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (status.done) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### src/skb_key_ram.sv
// Key store: one write port, one read port with registered read data.
module skb_key_ram import skb_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [KEY_W-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [KEY_W-1:0] rdata
);

	logic [KEY_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### src/skb_search_ctrl.sv
// Search sequencer: one probe per cycle, comparing the read key and halving the window.
module skb_search_ctrl import skb_pkg::*; #(
	parameter int TABLE_DEPTH = DEPTH_DEF,
	parameter int AW          = $clog2(TABLE_DEPTH),
	parameter int CW          = $clog2(TABLE_DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [KEY_W-1:0] key,
	input  logic [CW-1:0]    limit,
	output logic             rd_en,
	output logic [AW-1:0]    rd_addr,
	input  logic [KEY_W-1:0] rd_data,
	output skb_rsp_t         result,
	output skb_status_t      status
);

	typedef enum logic {
		ST_IDLE,
		ST_PROBE
	} state_t;

	state_t           state_q, state_n;
	logic [CW-1:0]    lo_q, hi_q, lo_n, hi_n;
	logic [AW-1:0]    mid_q, mid_n;
	logic [KEY_W-1:0] key_q, key_n;
	logic             done;

	// floor((lo + hi - 1) / 2) of the half-open window [lo, hi); caller guarantees lo < hi
	function automatic logic [AW-1:0] mid_of(input logic [CW-1:0] lo, input logic [CW-1:0] hi);
		logic [CW:0] s;
		s = {1'b0, lo} + {1'b0, hi} - (CW+1)'(1);
		return AW'(s >> 1);
	endfunction

	always_comb begin
		state_n = state_q;
		lo_n    = lo_q;
		hi_n    = hi_q;
		mid_n   = mid_q;
		key_n   = key_q;
		rd_en   = 1'b0;
		rd_addr = mid_q;
		done    = 1'b0;
		result  = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (limit == '0) begin
						done = 1'b1;
					end else begin
						lo_n    = '0;
						hi_n    = limit;
						mid_n   = mid_of('0, limit);
						key_n   = key;
						rd_en   = 1'b1;
						rd_addr = mid_n;
						state_n = ST_PROBE;
					end
				end
			end
			ST_PROBE: begin
				if (rd_data == key_q) begin
					done            = 1'b1;
					result.found    = 1'b1;
					result.position = POS_W'(mid_q);
					state_n         = ST_IDLE;
				end else begin
					if (key_q < rd_data) begin
						hi_n = CW'(mid_q);
					end else begin
						lo_n = CW'(mid_q) + CW'(1);
					end
					if (lo_n < hi_n) begin
						mid_n   = mid_of(lo_n, hi_n);
						rd_en   = 1'b1;
						rd_addr = mid_n;
					end else begin
						done    = 1'b1;
						state_n = ST_IDLE;
					end
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk) begin
		lo_q  <= lo_n;
		hi_q  <= hi_n;
		mid_q <= mid_n;
		key_q <= key_n;
	end

	assign status.busy = (state_q == ST_PROBE);
	assign status.done = done;

endmodule

### src/skb_checker.sv
// Port-level checker for the sorted key binary search block, bound to the top level.
`include "sorted_key_binary_search_assert.svh"

module skb_checker import skb_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_ready,
	input skb_req_t         req,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input skb_rsp_t         rsp,
	input logic             cfg_we,
	input logic [CNT_W-1:0] cfg_data
);

	logic load_fire;
	logic cfg_seen;

	assign load_fire = req_valid && req_ready && (req.command == CMD_LOAD);
	assign cfg_seen  = cfg_we || (cfg_data == cfg_data);

	// a stalled response holds
	`SKB_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

	// a miss always reports position zero
	`SKB_ASSERT_IMPLY(a_miss_pos, clk, arst_n, rsp_valid && !rsp.found && cfg_seen, rsp.position == '0)

	// no new request while a response is stuck at the output
	`SKB_ASSERT_IMPLY(a_block_on_stall, clk, arst_n, rsp_valid && !rsp_ready, !req_ready)

	// a load never produces a response
	`SKB_ASSERT_NEXT(a_load_silent, clk, arst_n, load_fire, !$rose(rsp_valid))

endmodule

bind sorted_key_binary_search skb_checker u_skb_checker (.*);
